/* hdl/bmpv_pkg.sv */
// bmpv_pkg: constants, header layout, status codes and shared types for the
// BMP stream validator. No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package bmpv_pkg;

    // Fixed file layout
    localparam int HEADER_BYTES = 54;
    localparam int DIB_BYTES    = 40;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    // Byte counter width and derived widths
    localparam int COUNT_BITS = 32;
    localparam int TOT_W      = 32;
    localparam int CMP_W      = ((COUNT_BITS > TOT_W) ? COUNT_BITS : TOT_W) + 1;
    localparam int ROW_W      = 33;   // row length in bytes, w > 0
    localparam int PROD_W     = 65;   // |height| * |row length|
    localparam int STATUS_W   = 4;
    localparam int BYTE_W     = 8;
    localparam int OUT_TDATA_W = ((STATUS_W + TOT_W + 7) / 8) * 8;

    // Header field constants
    localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
    localparam logic [15:0] BPP_24     = 16'd24;
    localparam logic [15:0] ONE_PLANE  = 16'd1;

    // Byte offsets of the header fields (little-endian)
    localparam int OFS_TYPE      = 0;
    localparam int OFS_SIZE      = 2;
    localparam int OFS_OFFSET    = 10;
    localparam int OFS_DIB       = 14;
    localparam int OFS_WIDTH     = 18;
    localparam int OFS_HEIGHT    = 22;
    localparam int OFS_PLANES    = 26;
    localparam int OFS_BPP       = 28;
    localparam int OFS_COMPR     = 30;
    localparam int OFS_IMG       = 34;
    localparam int OFS_COLOURS   = 46;
    localparam int OFS_IMPORTANT = 50;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_HDR_ONLY    = 4'd2,
        ST_TYPE        = 4'd3,
        ST_OFFSET      = 4'd4,
        ST_DIB         = 4'd5,
        ST_PLANES      = 4'd6,
        ST_COMPRESSION = 4'd7,
        ST_COLOURS     = 4'd8,
        ST_IMPORTANT   = 4'd9,
        ST_BPP         = 4'd10,
        ST_SIZE        = 4'd11,
        ST_PADDING     = 4'd12
    } status_t;

    // Captured header fields
    typedef struct packed {
        logic [15:0] magic;
        logic [31:0] file_size;
        logic [31:0] data_offset;
        logic [31:0] dib_size;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] compression;
        logic [31:0] image_size;
        logic [31:0] colours;
        logic [31:0] important;
    } hdr_t;

    // Derived row geometry and size verdict
    typedef struct packed {
        logic             track;     // width > 0, padding is checked
        logic [ROW_W-1:0] w3_pos;    // pixel bytes per row
        logic [ROW_W-1:0] row_last;  // last byte index in a padded row
        logic             geo_ok;    // header sizes agree with geometry
        logic [CMP_W-1:0] size_m1;   // file size minus one
    } geo_t;

endpackage

/* hdl/bmpv_header.sv */
// bmpv_header: captures the 54-byte file header into named field registers.
// Depends on bmpv_pkg.
`timescale 1ns / 1ps

module bmpv_header
    import bmpv_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [HDR_IDX_W-1:0] idx,
    input  logic [BYTE_W-1:0]    data,
    output hdr_t                 hdr
);

    hdr_t hdr_reg;

    // Byte lane decode per field; payload only, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (idx == HDR_IDX_W'(OFS_TYPE + k))   hdr_reg.magic[8*k +: 8]  <= data;
                if (idx == HDR_IDX_W'(OFS_PLANES + k)) hdr_reg.planes[8*k +: 8] <= data;
                if (idx == HDR_IDX_W'(OFS_BPP + k))    hdr_reg.bpp[8*k +: 8]    <= data;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (idx == HDR_IDX_W'(OFS_SIZE + k))      hdr_reg.file_size[8*k +: 8]   <= data;
                if (idx == HDR_IDX_W'(OFS_OFFSET + k))    hdr_reg.data_offset[8*k +: 8] <= data;
                if (idx == HDR_IDX_W'(OFS_DIB + k))       hdr_reg.dib_size[8*k +: 8]    <= data;
                if (idx == HDR_IDX_W'(OFS_WIDTH + k))     hdr_reg.width[8*k +: 8]       <= data;
                if (idx == HDR_IDX_W'(OFS_HEIGHT + k))    hdr_reg.height[8*k +: 8]      <= data;
                if (idx == HDR_IDX_W'(OFS_COMPR + k))     hdr_reg.compression[8*k +: 8] <= data;
                if (idx == HDR_IDX_W'(OFS_IMG + k))       hdr_reg.image_size[8*k +: 8]  <= data;
                if (idx == HDR_IDX_W'(OFS_COLOURS + k))   hdr_reg.colours[8*k +: 8]     <= data;
                if (idx == HDR_IDX_W'(OFS_IMPORTANT + k)) hdr_reg.important[8*k +: 8]   <= data;
            end
        end
    end

    assign hdr = hdr_reg;

endmodule

/* hdl/bmpv_geometry.sv */
// bmpv_geometry: four-stage pipeline that derives row length, expected pixel
// bytes and the size verdict from the captured header. Depends on bmpv_pkg.
`timescale 1ns / 1ps

module bmpv_geometry
    import bmpv_pkg::*;
(
    input  logic clk,
    input  hdr_t hdr,
    output geo_t geo
);

    // Stage A: width * 3, |height|
    logic signed [33:0] w3_a_reg;
    logic [31:0]        hu_a_reg;
    logic               h_neg_a_reg;
    logic               w_pos_a_reg;

    // Stage B: padded row length and its magnitude
    logic [ROW_W-1:0]   bu_b_reg;
    logic [31:0]        hu_b_reg;
    logic               mis_b_reg;
    logic               w_pos_b_reg;
    logic [ROW_W-1:0]   w3_b_reg;
    logic [ROW_W-1:0]   last_b_reg;

    // Stage C: product
    logic [PROD_W-1:0]  pb_c_reg;
    logic               mis_c_reg;

    // Stage D: verdict
    geo_t geo_reg;

    logic signed [33:0] w_ext;
    logic signed [33:0] bw;
    logic [1:0]         round_add;
    logic [32:0]        pb_plus_hdr;

    assign w_ext = {{2{hdr.width[31]}}, hdr.width};

    always_ff @(posedge clk)
    begin
        w3_a_reg    <= (w_ext <<< 1) + w_ext;
        hu_a_reg    <= hdr.height[31] ? (32'd0 - hdr.height) : hdr.height;
        h_neg_a_reg <= hdr.height[31];
        w_pos_a_reg <= !hdr.width[31] && (hdr.width != 32'd0);
    end

    // Round up towards plus infinity to a multiple of four
    assign round_add = 2'd0 - w3_a_reg[1:0];
    assign bw        = w3_a_reg + $signed({32'd0, round_add});

    always_ff @(posedge clk)
    begin
        bu_b_reg    <= bw[33] ? ROW_W'(-bw) : ROW_W'(bw);
        hu_b_reg    <= hu_a_reg;
        mis_b_reg   <= h_neg_a_reg != bw[33];
        w_pos_b_reg <= w_pos_a_reg;
        w3_b_reg    <= w3_a_reg[ROW_W-1:0];
        last_b_reg  <= ROW_W'(bw - 34'sd1);
    end

    always_ff @(posedge clk)
    begin
        pb_c_reg  <= PROD_W'(hu_b_reg) * PROD_W'(bu_b_reg);
        mis_c_reg <= mis_b_reg;
    end

    assign pb_plus_hdr = pb_c_reg[32:0] + 33'(HEADER_BYTES);

    always_ff @(posedge clk)
    begin
        geo_reg.track    <= w_pos_b_reg;
        geo_reg.w3_pos   <= w3_b_reg;
        geo_reg.row_last <= last_b_reg;
        geo_reg.geo_ok   <= !((pb_c_reg != '0) && mis_c_reg)
                            && (pb_c_reg[PROD_W-1:32] == '0)
                            && (hdr.image_size == pb_c_reg[31:0])
                            && ({1'b0, hdr.file_size} == pb_plus_hdr);
        geo_reg.size_m1  <= CMP_W'(hdr.file_size) - CMP_W'(1);
    end

    assign geo = geo_reg;

endmodule

/* hdl/bmp_stream_validator.sv */
// bmp_stream_validator: top level. Input register, byte counter, padding
// tracker, status priority and result register. Uses bmpv_header, bmpv_geometry.
`timescale 1ns / 1ps
//
//  channel   | dir | beat content                              | handshake
//  ----------+-----+-------------------------------------------+---------------
//  s_axis    | in  | tdata[7:0] file_byte, tlast = last         | tvalid/tready
//  m_axis    | out | tdata[3:0] status, [35:4] total_bytes      | tvalid/tready
//
//  One byte per clock sustained unless a last byte waits for the result register.
//  A result reaches m_axis via the input register, then the result register.
//  Reset clears the counters and flags; no clearing pass is needed.
//  Non-last bytes keep flowing while a result waits on m_axis; a last byte
//  waits in the input register until the result register is free.

module bmp_stream_validator
    import bmpv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] file_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [3:0] status, [35:4] total_bytes
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  s1_valid_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic                  s1_last_reg;

    logic [COUNT_BITS-1:0] count_reg;
    logic [ROW_W-1:0]      pos_reg;
    logic                  track_reg;
    logic                  fault_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [TOT_W-1:0]      out_total_reg;

    logic                  out_free;
    logic                  proc;
    logic                  hdr_we;
    logic                  hit;
    logic                  fault_next;
    logic                  size_ok;
    logic [COUNT_BITS-1:0] count_after;
    logic [TOT_W-1:0]      total_next;
    status_t               status_next;

    hdr_t hdr;
    geo_t geo;

    // Handshake: a last beat needs the result slot
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
    end

    // Header capture and geometry
    assign hdr_we = proc && (count_reg < COUNT_BITS'(HEADER_BYTES));

    bmpv_header u_header (
        .clk  (clk),
        .we   (hdr_we),
        .idx  (count_reg[HDR_IDX_W-1:0]),
        .data (s1_byte_reg),
        .hdr  (hdr)
    );

    bmpv_geometry u_geometry (
        .clk (clk),
        .hdr (hdr),
        .geo (geo)
    );

    // Per-beat counter and padding check
    assign count_after = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign hit         = !hdr_we && track_reg && (pos_reg >= geo.w3_pos)
                         && (s1_byte_reg != '0);
    assign fault_next  = fault_reg || hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            track_reg <= 1'b0;
            fault_reg <= 1'b0;
        end
        else if (proc)
        begin
            if (s1_last_reg)
            begin
                count_reg <= '0;
                pos_reg   <= '0;
                track_reg <= 1'b0;
                fault_reg <= 1'b0;
            end
            else
            begin
                count_reg <= count_after;
                fault_reg <= fault_next;
                if (count_reg == COUNT_BITS'(HEADER_BYTES - 1))
                begin
                    track_reg <= geo.track;
                    pos_reg   <= '0;
                end
                else if (!hdr_we && track_reg)
                begin
                    pos_reg <= (pos_reg == geo.row_last) ? '0 : pos_reg + 1'b1;
                end
            end
        end
    end

    // Final status, first failing check wins
    assign size_ok = geo.geo_ok
                     && (count_reg != CNT_MAX) && (count_reg != CNT_MAX - 1'b1)
                     && (CMP_W'(count_reg) == geo.size_m1);

    always_comb
    begin
        if (count_reg < COUNT_BITS'(HEADER_BYTES - 1))       status_next = ST_SHORT;
        else if (count_reg == COUNT_BITS'(HEADER_BYTES - 1)) status_next = ST_HDR_ONLY;
        else if (hdr.magic != BMP_MAGIC)                     status_next = ST_TYPE;
        else if (hdr.data_offset != 32'(HEADER_BYTES))       status_next = ST_OFFSET;
        else if (hdr.dib_size != 32'(DIB_BYTES))             status_next = ST_DIB;
        else if (hdr.planes != ONE_PLANE)                    status_next = ST_PLANES;
        else if (hdr.compression != '0)                      status_next = ST_COMPRESSION;
        else if (hdr.colours != '0)                          status_next = ST_COLOURS;
        else if (hdr.important != '0)                        status_next = ST_IMPORTANT;
        else if (hdr.bpp != BPP_24)                          status_next = ST_BPP;
        else if (!size_ok)                                   status_next = ST_SIZE;
        else if (fault_next)                                 status_next = ST_PADDING;
        else                                                 status_next = ST_OK;
    end

    assign total_next = (CMP_W'(count_after) > CMP_W'({TOT_W{1'b1}}))
                        ? {TOT_W{1'b1}} : TOT_W'(count_after);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && s1_last_reg)
        begin
            out_status_reg <= status_next;
            out_total_reg  <= total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - STATUS_W - TOT_W){1'b0}},
                            out_total_reg, out_status_reg};

    // Checks
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && s1_last_reg) |=> (count_reg == '0) && !track_reg && !fault_reg)
        else $error("state not cleared after last beat");

    a_row_pos: assert property (@(posedge clk) disable iff (!rst_n)
        track_reg |-> (pos_reg <= geo.row_last))
        else $error("row position beyond padded row");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc && s1_last_reg))
        else $error("result without a last beat");

    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_SHORT))
        |-> (out_total_reg < TOT_W'(HEADER_BYTES)))
        else $error("short status with full header count");

endmodule

/* tb/bmp_stream_validator_tb.sv */
// bmp_stream_validator_tb: self-checking testbench for the BMP stream validator.
// Streams whole files byte by byte, predicts each status beat and compares it.
// Depends on hdl/bmpv_pkg.sv and hdl/bmp_stream_validator.sv.
`timescale 1ns / 1ps

module bmp_stream_validator_tb;

    import bmpv_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    // Header fields that the stimulus can spoil
    typedef enum int {
        F_TYPE, F_OFFSET, F_DIB, F_PLANES, F_COMPR, F_COLOURS, F_IMPORTANT,
        F_BPP, F_SIZE, F_IMG, F_WIDTH, F_HEIGHT
    } hdr_field_t;

    typedef logic [BYTE_W-1:0] octet_t;

    typedef struct {
        status_t     status;
        logic [31:0] total;
    } verdict_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state for the file in flight
    octet_t          hdr_mem [HEADER_BYTES];
    longint unsigned byte_cnt;
    longint unsigned row_len;
    longint unsigned row_pos;
    bit              pad_bad;

    verdict_t pending_verdicts [$];
    octet_t   file_bytes [$];

    bit failed;
    bit src_idle_en;
    bit sink_idle_en;
    bit hold_req;
    int items_sent;

    bmp_stream_validator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic logic [15:0] le16(int at);
        return {hdr_mem[at + 1], hdr_mem[at]};
    endfunction

    function automatic logic [31:0] le32(int at);
        return {le16(at + 2), le16(at)};
    endfunction

    function automatic longint le_s32(int at);
        return longint'($signed(le32(at)));
    endfunction

    // round up to a multiple of four, towards plus infinity
    function automatic longint pad_to_word(longint n);
        longint m;
        m = n & 64'sd3;
        return n + ((64'sd4 - m) & 64'sd3);
    endfunction

    function automatic bit sizes_agree();
        longint          bw;
        longint          h;
        longint unsigned hu;
        longint unsigned bu;
        longint unsigned pix;
        longint unsigned fsize;
        longint unsigned isize;
        bw    = pad_to_word(le_s32(OFS_WIDTH) * 3);
        h     = le_s32(OFS_HEIGHT);
        hu    = (h < 0) ? -h : h;
        bu    = (bw < 0) ? -bw : bw;
        pix   = hu * bu;
        fsize = le32(OFS_SIZE);
        isize = le32(OFS_IMG);
        if (byte_cnt >= CNT_MAX)
            return 1'b0;
        if (pix != 0 && ((h < 0) != (bw < 0)))
            return 1'b0;
        if (pix > 64'hFFFF_FFFF)
            return 1'b0;
        if (byte_cnt != fsize || isize != pix || byte_cnt - HEADER_BYTES != pix ||
            fsize != pix + HEADER_BYTES)
            return 1'b0;
        return 1'b1;
    endfunction

    // first failing check in the order listed below decides
    function automatic status_t file_verdict();
        if (byte_cnt < HEADER_BYTES)          return ST_SHORT;
        if (byte_cnt == HEADER_BYTES)         return ST_HDR_ONLY;
        if (le16(OFS_TYPE) != BMP_MAGIC)      return ST_TYPE;
        if (le32(OFS_OFFSET) != HEADER_BYTES) return ST_OFFSET;
        if (le32(OFS_DIB) != DIB_BYTES)       return ST_DIB;
        if (le16(OFS_PLANES) != ONE_PLANE)    return ST_PLANES;
        if (le32(OFS_COMPR) != 0)             return ST_COMPRESSION;
        if (le32(OFS_COLOURS) != 0)           return ST_COLOURS;
        if (le32(OFS_IMPORTANT) != 0)         return ST_IMPORTANT;
        if (le16(OFS_BPP) != BPP_24)          return ST_BPP;
        if (!sizes_agree())                   return ST_SIZE;
        if (pad_bad)                          return ST_PADDING;
        return ST_OK;
    endfunction

    function automatic void clear_file_state();
        byte_cnt = 0;
        row_len  = 0;
        row_pos  = 0;
        pad_bad  = 1'b0;
    endfunction

    // advance the predictor by one accepted beat
    function automatic void track_byte(octet_t b, bit last);
        longint unsigned prior;
        longint          w;
        longint unsigned w3;
        verdict_t        v;
        prior = byte_cnt;
        if (byte_cnt < CNT_MAX)
            byte_cnt++;
        if (prior < HEADER_BYTES) begin
            hdr_mem[prior] = b;
            if (prior == HEADER_BYTES - 1) begin
                w       = le_s32(OFS_WIDTH);
                row_len = (w > 0) ? pad_to_word(w * 3) : 0;
                row_pos = 0;
            end
        end
        else if (row_len != 0) begin
            w3 = le_s32(OFS_WIDTH) * 3;
            if (row_pos >= w3 && b != 0)
                pad_bad = 1'b1;
            row_pos++;
            if (row_pos >= row_len)
                row_pos = 0;
        end
        if (last) begin
            v.status = file_verdict();
            v.total  = (byte_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : byte_cnt[31:0];
            pending_verdicts.push_back(v);
            clear_file_state();
        end
    endfunction

    // ---------------------------------------------------------------
    // File construction
    // ---------------------------------------------------------------

    task automatic put_le(int at, logic [31:0] val, int n);
        for (int i = 0; i < n; i++)
            file_bytes[at + i] = val[8*i +: 8];
    endtask

    task automatic flip_bits(int at, int n);
        int idx;
        idx = at + $urandom_range(0, n - 1);
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
    endtask

    // well-formed 24-bit image; keep |h| * row length small
    task automatic make_image(int w, int h);
        longint          w3;
        longint          bw;
        longint unsigned rows;
        longint unsigned row_bytes;
        longint unsigned pix;
        w3        = longint'(w) * 3;
        bw        = pad_to_word(w3);
        rows      = (h < 0) ? -longint'(h) : h;
        row_bytes = (bw < 0) ? -bw : bw;
        pix       = rows * row_bytes;
        file_bytes.delete();
        repeat (HEADER_BYTES) file_bytes.push_back(8'($urandom_range(0, 255)));
        put_le(OFS_TYPE, BMP_MAGIC, 2);
        put_le(OFS_SIZE, 32'(pix + HEADER_BYTES), 4);
        put_le(OFS_OFFSET, HEADER_BYTES, 4);
        put_le(OFS_DIB, DIB_BYTES, 4);
        put_le(OFS_WIDTH, w, 4);
        put_le(OFS_HEIGHT, h, 4);
        put_le(OFS_PLANES, ONE_PLANE, 2);
        put_le(OFS_BPP, BPP_24, 2);
        put_le(OFS_COMPR, 0, 4);
        put_le(OFS_IMG, 32'(pix), 4);
        put_le(OFS_COLOURS, 0, 4);
        put_le(OFS_IMPORTANT, 0, 4);
        // pixel rows, padding zeroed where it is tracked; empty rows add nothing
        if (row_bytes != 0)
            for (longint unsigned r = 0; r < rows; r++)
                for (longint unsigned c = 0; c < row_bytes; c++)
                    file_bytes.push_back((w > 0 && c >= w3) ? 8'h00
                                                            : 8'($urandom_range(0, 255)));
    endtask

    task automatic make_noise(int n);
        file_bytes.delete();
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic spoil_field(hdr_field_t f);
        case (f)
            F_TYPE:      flip_bits(OFS_TYPE, 2);
            F_OFFSET:    flip_bits(OFS_OFFSET, 4);
            F_DIB:       flip_bits(OFS_DIB, 4);
            F_PLANES:    flip_bits(OFS_PLANES, 2);
            F_COMPR:     flip_bits(OFS_COMPR, 4);
            F_COLOURS:   flip_bits(OFS_COLOURS, 4);
            F_IMPORTANT: flip_bits(OFS_IMPORTANT, 4);
            F_BPP:       flip_bits(OFS_BPP, 2);
            F_SIZE:      flip_bits(OFS_SIZE, 4);
            F_IMG:       flip_bits(OFS_IMG, 4);
            F_WIDTH:     flip_bits(OFS_WIDTH, 4);
            default:     flip_bits(OFS_HEIGHT, 4);
        endcase
    endtask

    // put a nonzero byte into one padding slot (w must leave padding)
    task automatic dirty_padding(int w, int h);
        int row_bytes;
        int r;
        int c;
        row_bytes = int'(pad_to_word(w * 3));
        r = $urandom_range(0, h - 1);
        c = $urandom_range(w * 3, row_bytes - 1);
        file_bytes[HEADER_BYTES + r * row_bytes + c] = 8'($urandom_range(1, 255));
    endtask

    // ---------------------------------------------------------------
    // Sending
    // ---------------------------------------------------------------

    // one beat; called at a rising edge, returns at the accepting edge
    task automatic send_file_byte(octet_t b, bit last);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        track_byte(b, last);
        items_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_file_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_short_files();
        file_bytes.delete();
        file_bytes.push_back(8'hFF);
        send_file();
        file_bytes.delete();
        repeat (HEADER_BYTES - 1) file_bytes.push_back(8'h00);
        send_file();
        // header alone, nothing after it
        make_image(1, 1);
        while (file_bytes.size() > HEADER_BYTES) void'(file_bytes.pop_back());
        send_file();
    endtask

    task automatic test_header_fields();
        for (int k = F_TYPE; k <= F_BPP; k++) begin
            make_image(1, 1);
            spoil_field(hdr_field_t'(k));
            send_file();
        end
    endtask

    task automatic test_geometry();
        make_image(4, 2);
        send_file();
        // negative width and height with matching sizes is fine
        make_image(-2, -1);
        send_file();
        // positive width, negative height
        make_image(3, -2);
        send_file();
        // zero-length rows and extreme widths: any pixel byte is too many
        make_image(-1, 3);
        file_bytes.push_back(8'h00);
        send_file();
        make_image(int'(32'h7FFF_FFFF), 0);
        file_bytes.push_back(8'hFF);
        send_file();
        make_image(int'(32'h8000_0000), 0);
        file_bytes.push_back(8'h00);
        send_file();
        make_image(0, int'(32'h7FFF_FFFF));
        file_bytes.push_back(8'h00);
        send_file();
        // one byte too many, then a wrong image size field
        make_image(2, 2);
        file_bytes.push_back(8'h00);
        send_file();
        make_image(2, 1);
        spoil_field(F_IMG);
        send_file();
    endtask

    task automatic test_padding();
        make_image(1, 2);
        file_bytes[HEADER_BYTES + 4 + 3] = 8'h01;
        send_file();
        // last pixel byte of a row may be anything
        make_image(5, 1);
        file_bytes[HEADER_BYTES + 14] = 8'hFF;
        send_file();
        // a size error outranks dirty padding
        make_image(2, 3);
        dirty_padding(2, 3);
        spoil_field(F_SIZE);
        send_file();
    endtask

    // receiver stalls long while short files keep coming, so the block backs up
    task automatic test_result_backpressure();
        bit keep_idle;
        keep_idle   = src_idle_en;
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        repeat (12) begin
            make_noise($urandom_range(1, 4));
            send_file();
        end
        make_image(2, 2);
        send_file();
        src_idle_en = keep_idle;
    endtask

    task automatic random_file();
        int pick;
        int w;
        int h;
        pick = $urandom_range(0, 99);
        w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4)) - 4
                                        : int'($urandom_range(1, 7));
        h = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 3)) - 3
                                        : int'($urandom_range(1, 5));
        if (pick < 8)
            make_noise($urandom_range(1, HEADER_BYTES - 1));
        else if (pick < 12)
            make_noise($urandom_range(HEADER_BYTES, HEADER_BYTES + 40));
        else if (pick < 16) begin
            make_image(w, h);
            while (file_bytes.size() > HEADER_BYTES) void'(file_bytes.pop_back());
        end
        else if (pick < 60)
            make_image(w, h);
        else if (pick < 78) begin
            make_image(w, h);
            spoil_field(hdr_field_t'($urandom_range(F_TYPE, F_HEIGHT)));
        end
        else if (pick < 90) begin
            // widths that leave padding in every row
            w = 4 * $urandom_range(0, 1) + $urandom_range(1, 3);
            h = $urandom_range(1, 4);
            make_image(w, h);
            dirty_padding(w, h);
        end
        else begin
            make_image(w, h);
            if ($urandom_range(0, 1) == 0)
                file_bytes.push_back(8'($urandom_range(0, 255)));
            else if (file_bytes.size() > HEADER_BYTES)
                void'(file_bytes.pop_back());
        end
    endtask

    task automatic test_random_files(int min_items, int min_files);
        int items0;
        int files;
        items0 = items_sent;
        files  = 0;
        while (items_sent - items0 < min_items || files < min_files) begin
            random_file();
            send_file();
            files++;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver ready: random stall bursts, plus one long hold on request
    // ---------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: each status beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk) begin : check_verdict
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, status %0d total %0d", $time,
                         m_axis_tdata[STATUS_W-1:0], m_axis_tdata[STATUS_W +: TOT_W]);
                failed = 1'b1;
            end
            else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[STATUS_W-1:0] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             want.status, m_axis_tdata[STATUS_W-1:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[STATUS_W +: TOT_W] !== want.total) begin
                    $display("%0t: total_bytes mismatch, expected %0d, got %0d", $time,
                             want.total, m_axis_tdata[STATUS_W +: TOT_W]);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        failed        = 1'b0;
        hold_req      = 1'b0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        items_sent    = 0;
        clear_file_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_files();
        test_header_fields();
        test_geometry();
        test_padding();
        test_result_backpressure();
        test_random_files(40, 1);
        // closing stretch at full rate on both sides
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_files(40, 1);
        s_axis_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && pending_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
